/* design/zzv_pkg.sv */
// Package with operation codes and controller/datapath interface types.
`timescale 1ns / 1ps

package zzv_pkg;

  localparam logic [3:0] OP_SVARINT32 = 4'd0;
  localparam logic [3:0] OP_SVARINT64 = 4'd1;
  localparam logic [3:0] OP_UVARINT32 = 4'd2;
  localparam logic [3:0] OP_UVARINT64 = 4'd3;
  localparam logic [3:0] OP_FIXED16   = 4'd4;
  localparam logic [3:0] OP_FIXED32   = 4'd5;
  localparam logic [3:0] OP_FIXED64   = 4'd6;
  localparam logic [3:0] OP_RAW_BYTE  = 4'd7;
  localparam logic [3:0] OP_LEN_HDR   = 4'd8;

  localparam int unsigned MaxBytes   = 10;
  localparam int unsigned CountWidth = 4;

  typedef logic [CountWidth-1:0] count_t;

  typedef struct packed {
    logic load;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic no_bytes;
    logic last;
  } dp_status_t;

endpackage

/* design/zzv_ctrl.sv */
// Controller state machine that sequences the bytes of one field item.
`timescale 1ns / 1ps

module zzv_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  zzv_pkg::dp_status_t status_i,
  output zzv_pkg::ctrl_cmd_t  cmd_o
);
  import zzv_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_q, state_d;
  logic busy;

  assign busy        = (state_q == ST_EMIT);
  assign in_ready_o  = !busy || (out_ready_i && status_i.last);
  assign out_valid_o = busy;
  assign cmd_o.load  = in_valid_i && in_ready_o;
  assign cmd_o.step  = busy && out_ready_i;

  always_comb begin
    state_d = state_q;
    if (cmd_o.load) begin
      state_d = status_i.no_bytes ? ST_IDLE : ST_EMIT;
    end else if (cmd_o.step && status_i.last) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/zzv_datapath.sv */
// Datapath: operand encoding, byte count, byte shifter and address counter.
`timescale 1ns / 1ps

module zzv_datapath #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  zzv_pkg::ctrl_cmd_t  cmd_i,
  output zzv_pkg::dp_status_t status_o,
  input  logic [3:0]          op_i,
  input  logic [63:0]         value_i,
  input  logic [15:0]         offset_i,
  output logic [7:0]          out_byte_o,
  output logic [15:0]         out_address_o,
  output logic                last_o,
  output logic [15:0]         next_offset_o
);
  import zzv_pkg::*;

  localparam logic [63:0] LenMask  = (64'd1 << OFFSET_BITS) - 64'd1;
  localparam logic [15:0] AddrMask = (OFFSET_BITS >= 16) ? 16'hFFFF : LenMask[15:0];

  logic [63:0] enc;
  logic        is_varint;
  count_t      fixed_n;
  count_t      varint_n;
  count_t      n_d;
  logic [9:0]  grp_nz;
  logic [31:0] zz_src;
  logic [31:0] zz32;
  logic [15:0] base;

  logic [63:0] shift_q;
  count_t      left_q;
  logic        varint_q;
  logic [15:0] addr_q;
  logic [15:0] next_q;

  assign zz_src = (op_i == OP_LEN_HDR) ? (value_i[31:0] & LenMask[31:0]) : value_i[31:0];
  assign zz32   = {zz_src[30:0], 1'b0} ^ {32{zz_src[31]}};

  always_comb begin
    enc       = value_i;
    is_varint = 1'b0;
    fixed_n   = '0;
    case (op_i)
      OP_SVARINT32, OP_LEN_HDR: begin
        enc       = {32'd0, zz32};
        is_varint = 1'b1;
      end
      OP_SVARINT64: begin
        enc       = {value_i[62:0], 1'b0} ^ {64{value_i[63]}};
        is_varint = 1'b1;
      end
      OP_UVARINT32: begin
        enc       = {32'd0, value_i[31:0]};
        is_varint = 1'b1;
      end
      OP_UVARINT64: begin
        is_varint = 1'b1;
      end
      OP_FIXED16:  fixed_n = count_t'(2);
      OP_FIXED32:  fixed_n = count_t'(4);
      OP_FIXED64:  fixed_n = count_t'(8);
      OP_RAW_BYTE: fixed_n = count_t'(1);
      default:     fixed_n = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      grp_nz[i] = |enc[7*i +: 7];
    end
    grp_nz[9] = enc[63];
    varint_n = count_t'(1);
    for (int i = 1; i < MaxBytes; i++) begin
      if (grp_nz[i]) begin
        varint_n = count_t'(i + 1);
      end
    end
  end

  assign n_d  = is_varint ? varint_n : fixed_n;
  assign base = offset_i & AddrMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (cmd_i.load) begin
      left_q <= n_d;
    end else if (cmd_i.step) begin
      left_q <= left_q - count_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      shift_q  <= enc;
      varint_q <= is_varint;
      addr_q   <= base;
      next_q   <= (base + {{(16-CountWidth){1'b0}}, n_d}) & AddrMask;
    end else if (cmd_i.step) begin
      shift_q <= varint_q ? {7'd0, shift_q[63:7]} : {8'd0, shift_q[63:8]};
      addr_q  <= (addr_q + 16'd1) & AddrMask;
    end
  end

  assign status_o.no_bytes = (n_d == '0);
  assign status_o.last     = (left_q == count_t'(1));

  assign out_byte_o    = varint_q ? {!status_o.last, shift_q[6:0]} : shift_q[7:0];
  assign out_address_o = addr_q;
  assign last_o        = status_o.last;
  assign next_offset_o = next_q;

endmodule

/* design/zigzag_varint_field_encoder.sv */
// Top level of the zigzag and varint field encoder.
//
//  channel | direction | payload                                   | handshake
//  in      | input     | op_i, value_i, offset_i                   | in_valid_i / in_ready_o
//  out     | output    | out_byte_o, out_address_o, last_o,        | out_valid_o / out_ready_i
//          |           | next_offset_o                             |
//
// An item emits one byte per cycle while out_ready_i is high: 1 to 10 bytes, set by the byte
// counter in the datapath. The next item is taken in the cycle its last byte leaves.
// An undefined operation is accepted and emits nothing.
// Reset clears only the controller state and the byte counter.
// A stalled output holds its byte and address until it is taken.
`timescale 1ns / 1ps

module zigzag_varint_field_encoder #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  op_i,
  input  logic [63:0] value_i,
  input  logic [15:0] offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [15:0] out_address_o,
  output logic        last_o,
  output logic [15:0] next_offset_o
);
  import zzv_pkg::*;

  localparam logic [15:0] AddrMask =
    (OFFSET_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << OFFSET_BITS) - 32'd1);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  zzv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  zzv_datapath #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .op_i          (op_i),
    .value_i       (value_i),
    .offset_i      (offset_i),
    .out_byte_o    (out_byte_o),
    .out_address_o (out_address_o),
    .last_o        (last_o),
    .next_offset_o (next_offset_o)
  );

  a_last_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> next_offset_o == ((out_address_o + 16'd1) & AddrMask))
    else $error("next offset does not follow the last byte address");

  a_addr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      out_valid_o && out_address_o == (($past(out_address_o) + 16'd1) & AddrMask))
    else $error("address did not advance within a run");

  a_next_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> $stable(next_offset_o))
    else $error("next offset changed within a run");

  a_no_early_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !(out_ready_i && last_o) |-> !in_ready_o)
    else $error("new item taken while a run is pending");

endmodule
